// ===== rtl/qrs_pkg.sv =====
`timescale 1ns / 1ps

package qrs_pkg;

  // Width of each root field on the result channel (signed fixed point).
  localparam int ROOT_W = 34;

  // Result channel payload widths.
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  // Side bits carried through the divider chain: status and two negate flags.
  localparam int DIV_SIDE_W = 4;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_ONE    = 2'd1,
    ST_TWO    = 2'd2,
    ST_LINEAR = 2'd3
  } status_t;

endpackage

// ===== rtl/quadratic_root_solver_unit.sv =====
`timescale 1ns / 1ps

// Quadratic root solver for a*x^2 + b*x + c = 0. Each input beat carries three
// signed integer coefficients and yields exactly one result beat: a status
// (no real root, one root, two roots, or not second order when a is zero) and
// the two roots (-b +/- sqrt(b^2-4ac))/(2a) in signed fixed point with
// FRAC_BITS fraction bits, rounded to nearest with ties toward plus infinity.
// Both roots read zero when there is no real root or a is zero. The block
// takes one beat per clock cycle. Most of the pipeline lies in two chains
// of cells: a square root chain that retires one radix-4 digit per cell
// (COEF_BITS+1+FRAC_BITS cells) and a divider chain that retires one
// quotient bit per cell for both roots at once (COEF_BITS+FRAC_BITS+3
// cells). The whole pipeline advances together; it holds while a result
// waits on out_tready, so in_tready follows out_tready whenever the output
// register is full.
module quadratic_root_solver_unit #(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata, lowest bit first: coef_a, coef_b, coef_c, zero fill to bytes.
  input  logic [((3*COEF_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata, lowest bit first: root_plus[33:0], root_minus[67:34], zero fill.
  output logic [qrs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: status[1:0].
  output logic [qrs_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready
);

  import qrs_pkg::*;

  localparam int CB     = COEF_BITS;
  localparam int DW     = 2*CB + 2;          // signed discriminant width
  localparam int NI     = CB + 1;            // integer digits of the square root
  localparam int RB     = NI + FRAC_BITS;    // square root result width
  localparam int NSQ    = RB;                // cells in the square root chain
  localparam int RAD_W  = 2*NI;
  localparam int SIDE_W = 2 + 1 + 2*CB;      // status, sign of a, |a|, b
  localparam int D_W    = CB + 1;            // divisor 2|a|
  localparam int NW     = CB + FRAC_BITS + 3;// numerator and quotient width
  localparam int QS     = NW + 1;            // signed quotient width
  localparam int XW     = (QS > ROOT_W) ? QS : ROOT_W;

  localparam logic signed [XW-1:0] SAT_HI = {{(XW-ROOT_W+1){1'b0}}, {(ROOT_W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

  logic en;
  logic out_valid_r;

  // The output register parts the two sides; everything advances on en.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 0: capture the coefficients.
  // ---------------------------------------------------------------------------
  logic                 s0_valid_r;
  logic signed [CB-1:0] s0_a_r, s0_b_r, s0_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a_r <= signed'(in_tdata[CB-1:0]);
      s0_b_r <= signed'(in_tdata[2*CB-1:CB]);
      s0_c_r <= signed'(in_tdata[3*CB-1:2*CB]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the two products of the discriminant.
  // ---------------------------------------------------------------------------
  logic                   s1_valid_r;
  logic signed [2*CB-1:0] s1_bb_r, s1_ac_r;
  logic signed [CB-1:0]   s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bb_r <= (2*CB)'(s0_b_r) * (2*CB)'(s0_b_r);
      s1_ac_r <= (2*CB)'(s0_a_r) * (2*CB)'(s0_c_r);
      s1_a_r  <= s0_a_r;
      s1_b_r  <= s0_b_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: discriminant, status and the load of the square root chain.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] disc;
  logic [CB-1:0]        a_mag;
  logic                 a_neg;
  status_t              s2_status;

  always_comb begin
    disc  = DW'(s1_bb_r) - (DW'(s1_ac_r) <<< 2);
    a_neg = s1_a_r[CB-1];
    a_mag = a_neg ? (~s1_a_r + 1'b1) : s1_a_r;
    // A zero a is reported first, whatever the discriminant says.
    if (s1_a_r == '0) begin
      s2_status = ST_LINEAR;
    end else if (disc[DW-1]) begin
      s2_status = ST_NONE;
    end else if (disc == '0) begin
      s2_status = ST_ONE;
    end else begin
      s2_status = ST_TWO;
    end
  end

  logic              s2_valid_r;
  logic [RAD_W-1:0]  s2_rad_r;
  logic [SIDE_W-1:0] s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rad_r  <= RAD_W'(disc);
      s2_side_r <= {s2_status, a_neg, a_mag, s1_b_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Square root chain: floor(sqrt(disc * 4^FRAC_BITS)), one digit per cell.
  // ---------------------------------------------------------------------------
  logic              sq_valid [0:NSQ];
  logic [RAD_W-1:0]  sq_rad   [0:NSQ];
  logic [RB+1:0]     sq_rem   [0:NSQ];
  logic [RB-1:0]     sq_root  [0:NSQ];
  logic [SIDE_W-1:0] sq_side  [0:NSQ];

  assign sq_valid[0] = s2_valid_r;
  assign sq_rad[0]   = s2_rad_r;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = s2_side_r;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .RAD_W    (RAD_W),
      .ROOT_BITS(RB),
      .SIDE_W   (SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .valid_i(sq_valid[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .valid_o(sq_valid[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 3: signed numerators. With s the sign of a, the scaled root is
  // floor((s*(-b)*2^F + |a| + s*e*sqrt(D)*2^F) / (2|a|)); the floor of the
  // negated square root is -(r+1) unless the root was exact.
  // ---------------------------------------------------------------------------
  status_t              s3_status;
  logic                 s3_a_neg;
  logic [CB-1:0]        s3_mag;
  logic signed [CB-1:0] s3_b;
  logic signed [CB:0]   nb;
  logic signed [NW-1:0] base, r_x, inx, n_p, n_m;

  always_comb begin
    s3_status = status_t'(sq_side[NSQ][SIDE_W-1 -: 2]);
    s3_a_neg  = sq_side[NSQ][2*CB];
    s3_mag    = sq_side[NSQ][2*CB-1:CB];
    s3_b      = signed'(sq_side[NSQ][CB-1:0]);
    nb        = s3_a_neg ? (CB+1)'(s3_b) : -((CB+1)'(s3_b));
    base      = (NW'(nb) <<< FRAC_BITS) + signed'(NW'(s3_mag));
    r_x       = signed'(NW'(sq_root[NSQ]));
    inx       = signed'(NW'(sq_rem[NSQ] != '0));
    n_p       = s3_a_neg ? (base - r_x - inx) : (base + r_x);
    n_m       = s3_a_neg ? (base + r_x) : (base - r_x - inx);
  end

  logic                 s3_valid_r;
  logic signed [NW-1:0] s3_np_r, s3_nm_r;
  logic [D_W-1:0]       s3_div_r;
  status_t              s3_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= sq_valid[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_np_r     <= n_p;
      s3_nm_r     <= n_m;
      s3_div_r    <= {s3_mag, 1'b0};
      s3_status_r <= s3_status;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: floor division of a negative numerator becomes an unsigned
  // division of |n| + d - 1, which is ~n + d, negated afterwards.
  // ---------------------------------------------------------------------------
  logic              s4_valid_r;
  logic [NW-1:0]     s4_up_r, s4_um_r;
  logic [D_W-1:0]    s4_div_r;
  logic [DIV_SIDE_W-1:0] s4_side_r;
  logic [NW-1:0]     u_p, u_m;

  always_comb begin
    u_p = s3_np_r[NW-1] ? (~s3_np_r + NW'(s3_div_r)) : s3_np_r;
    u_m = s3_nm_r[NW-1] ? (~s3_nm_r + NW'(s3_div_r)) : s3_nm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_up_r   <= u_p;
      s4_um_r   <= u_m;
      s4_div_r  <= s3_div_r;
      s4_side_r <= {s3_status_r, s3_np_r[NW-1], s3_nm_r[NW-1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Divider chain: both roots share the divisor, one quotient bit per cell.
  // ---------------------------------------------------------------------------
  logic                  dv_valid [0:NW];
  logic [D_W-1:0]        dv_div   [0:NW];
  logic [D_W-1:0]        dv_rem_p [0:NW];
  logic [NW-1:0]         dv_nq_p  [0:NW];
  logic [D_W-1:0]        dv_rem_m [0:NW];
  logic [NW-1:0]         dv_nq_m  [0:NW];
  logic [DIV_SIDE_W-1:0] dv_side  [0:NW];

  assign dv_valid[0] = s4_valid_r;
  assign dv_div[0]   = s4_div_r;
  assign dv_rem_p[0] = '0;
  assign dv_nq_p[0]  = s4_up_r;
  assign dv_rem_m[0] = '0;
  assign dv_nq_m[0]  = s4_um_r;
  assign dv_side[0]  = s4_side_r;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qrs_div_cell #(
      .D_W (D_W),
      .NQ_W(NW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .valid_i(dv_valid[j]),
      .div_i  (dv_div[j]),
      .rem_p_i(dv_rem_p[j]),
      .nq_p_i (dv_nq_p[j]),
      .rem_m_i(dv_rem_m[j]),
      .nq_m_i (dv_nq_m[j]),
      .side_i (dv_side[j]),
      .valid_o(dv_valid[j+1]),
      .div_o  (dv_div[j+1]),
      .rem_p_o(dv_rem_p[j+1]),
      .nq_p_o (dv_nq_p[j+1]),
      .rem_m_o(dv_rem_m[j+1]),
      .nq_m_o (dv_nq_m[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: restore the sign, saturate, and zero the roots when the
  // status says there are none.
  // ---------------------------------------------------------------------------
  status_t              o_status;
  logic signed [XW-1:0] q_p, q_m, c_p, c_m;
  logic [ROOT_W-1:0]    root_p, root_m;

  always_comb begin
    o_status = status_t'(dv_side[NW][3:2]);
    q_p = dv_side[NW][1] ? -XW'({1'b0, dv_nq_p[NW]}) : XW'({1'b0, dv_nq_p[NW]});
    q_m = dv_side[NW][0] ? -XW'({1'b0, dv_nq_m[NW]}) : XW'({1'b0, dv_nq_m[NW]});
    c_p = (q_p > SAT_HI) ? SAT_HI : ((q_p < SAT_LO) ? SAT_LO : q_p);
    c_m = (q_m > SAT_HI) ? SAT_HI : ((q_m < SAT_LO) ? SAT_LO : q_m);
    if (o_status == ST_NONE || o_status == ST_LINEAR) begin
      root_p = '0;
      root_m = '0;
    end else begin
      root_p = c_p[ROOT_W-1:0];
      root_m = c_m[ROOT_W-1:0];
    end
  end

  logic [ROOT_W-1:0]      out_rp_r, out_rm_r;
  status_t                out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rp_r     <= root_p;
      out_rm_r     <= root_m;
      out_status_r <= o_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2*ROOT_W){1'b0}}, out_rm_r, out_rp_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/qrs_sqrt_cell.sv =====
`timescale 1ns / 1ps

module qrs_sqrt_cell #(
  parameter int RAD_W     = 34,
  parameter int ROOT_BITS = 33,
  parameter int SIDE_W    = 35
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [ROOT_BITS+1:0] rem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [RAD_W-1:0]     rad_o,
  output logic [ROOT_BITS+1:0] rem_o,
  output logic [ROOT_BITS-1:0] root_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic                 valid_r;
  logic [RAD_W-1:0]     rad_r;
  logic [ROOT_BITS+1:0] rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [SIDE_W-1:0]    side_r;
  logic [ROOT_BITS+1:0] rem_sh, trial;
  logic                 take;

  // One radix-4 digit of the restoring square root: bring down two bits and
  // try to subtract 4*root+1.
  always_comb begin
    rem_sh   = {rem_i[ROOT_BITS-1:0], rad_i[RAD_W-1 -: 2]};
    trial    = {root_i, 2'b01};
    take     = (rem_sh >= trial);
    rem_nxt  = take ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[ROOT_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;

endmodule

// ===== rtl/qrs_div_cell.sv =====
`timescale 1ns / 1ps

module qrs_div_cell #(
  parameter int D_W  = 17,
  parameter int NQ_W = 35
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_i,
  input  logic [D_W-1:0]                div_i,
  input  logic [D_W-1:0]                rem_p_i,
  input  logic [NQ_W-1:0]               nq_p_i,
  input  logic [D_W-1:0]                rem_m_i,
  input  logic [NQ_W-1:0]               nq_m_i,
  input  logic [qrs_pkg::DIV_SIDE_W-1:0] side_i,
  output logic                          valid_o,
  output logic [D_W-1:0]                div_o,
  output logic [D_W-1:0]                rem_p_o,
  output logic [NQ_W-1:0]               nq_p_o,
  output logic [D_W-1:0]                rem_m_o,
  output logic [NQ_W-1:0]               nq_m_o,
  output logic [qrs_pkg::DIV_SIDE_W-1:0] side_o
);

  import qrs_pkg::*;

  logic                  valid_r;
  logic [D_W-1:0]        div_r;
  logic [D_W-1:0]        rem_p_r, rem_p_nxt, rem_m_r, rem_m_nxt;
  logic [NQ_W-1:0]       nq_p_r, nq_p_nxt, nq_m_r, nq_m_nxt;
  logic [DIV_SIDE_W-1:0] side_r;
  logic [D_W:0]          sh_p, sh_m;
  logic                  q_p, q_m;

  // One restoring division step per lane. The numerator shifts out at the
  // top of nq while quotient bits shift in at the bottom.
  always_comb begin
    sh_p      = {rem_p_i, nq_p_i[NQ_W-1]};
    sh_m      = {rem_m_i, nq_m_i[NQ_W-1]};
    q_p       = (sh_p >= {1'b0, div_i});
    q_m       = (sh_m >= {1'b0, div_i});
    rem_p_nxt = q_p ? D_W'(sh_p - {1'b0, div_i}) : sh_p[D_W-1:0];
    rem_m_nxt = q_m ? D_W'(sh_m - {1'b0, div_i}) : sh_m[D_W-1:0];
    nq_p_nxt  = {nq_p_i[NQ_W-2:0], q_p};
    nq_m_nxt  = {nq_m_i[NQ_W-2:0], q_m};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r   <= div_i;
      rem_p_r <= rem_p_nxt;
      rem_m_r <= rem_m_nxt;
      nq_p_r  <= nq_p_nxt;
      nq_m_r  <= nq_m_nxt;
      side_r  <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign div_o   = div_r;
  assign rem_p_o = rem_p_r;
  assign nq_p_o  = nq_p_r;
  assign rem_m_o = rem_m_r;
  assign nq_m_o  = nq_m_r;
  assign side_o  = side_r;

endmodule

// ===== rtl/qrs_checker.sv =====
`timescale 1ns / 1ps

module qrs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [qrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [qrs_pkg::OUT_TUSER_W-1:0] out_tuser
);

  import qrs_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // No real root or a zero leading coefficient gives zero roots.
  a_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NONE || out_tuser == ST_LINEAR) |->
      out_tdata[2*ROOT_W-1:0] == '0)
    else $error("roots not zero for a rootless status");

  // A double root shows the same value in both fields.
  a_double_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_ONE |->
      out_tdata[ROOT_W-1:0] == out_tdata[2*ROOT_W-1:ROOT_W])
    else $error("double root fields differ");

  // The pipeline takes input exactly when the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output side");

  // Reset leaves no result beat behind.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
